// ===== design/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg: shared constants and types for the pose frame decoder
// Frame layout byte positions, sign thresholds and yaw scaling constants.
// ----------------------------------------------------------------------------
package pfd_pkg;

    // frame layout
    localparam logic [4:0] FRAME_LEN     = 5'd21;
    localparam logic [4:0] IDX_FLAG      = 5'd1;
    localparam logic [4:0] IDX_X_FIRST   = 5'd2;
    localparam logic [4:0] IDX_X_LAST    = 5'd5;
    localparam logic [4:0] IDX_Y_FIRST   = 5'd6;
    localparam logic [4:0] IDX_Y_LAST    = 5'd7;
    localparam logic [4:0] IDX_ANG_FIRST = 5'd10;
    localparam logic [4:0] IDX_ANG_LAST  = 5'd11;
    localparam logic [4:0] IDX_TAG_FIRST = 5'd14;
    localparam logic [4:0] IDX_TAG_LAST  = 5'd17;
    localparam int         FLAG_BIT      = 6;

    // sign folding thresholds
    localparam logic [29:0] X_HALF = 30'h0080_0000;
    localparam logic [29:0] X_SPAN = 30'h0100_0000;
    localparam logic [15:0] Y_HALF = 16'h2000;
    localparam logic [15:0] Y_SPAN = 16'h4000;
    localparam logic [24:0] X_SAT  = 25'h180_0000;   // -8388608
    localparam logic [14:0] Y_SAT  = 15'h6000;       // -8192

    // angle handling
    localparam logic [13:0] ANG_MAX  = 14'h3FFF;
    localparam logic [13:0] ANG_HALF = 14'd1800;
    localparam logic [14:0] ANG_FULL = 15'd3600;

    // yaw to radians Q16: (yaw * YAW_SCALE + YAW_ROUND) >>> 8
    localparam logic signed [31:0] YAW_SCALE = 32'sd29282;
    localparam logic signed [31:0] YAW_ROUND = 32'sd128;

    // completed frame handed from the accumulator stage to the convert stage
    typedef struct packed {
        logic [29:0]        x;
        logic [15:0]        y;
        logic signed [14:0] yaw;
        logic [29:0]        tag;
    } frame_snap_t;

endpackage

// ===== design/pose_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// pose_frame_decoder_core: byte-stream position frame decoder
// Accumulates a 21-byte frame, checks XOR checksum and on-code flag, and
// emits x/y offsets, yaw and tag for every good frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one frame byte per transfer with
//   chunk_end marking the last byte of a received chunk.
//   Output channel (out_valid/out_stall): one decoded pose per good frame.
//   Throughput: one byte per cycle while the output is not stalled.
//   A result passes from the transfer of the byte carrying chunk_end through
//   the input register and the accumulate/snapshot register, then through
//   the convert stage with its single multiply into the output register.
//   A chunk shorter than 21 bytes, a bad checksum or a clear on-code flag
//   gives no result; bytes beyond the 21st are ignored until chunk_end.
//   Reset clears the frame state and all valid flags; no clearing pass.
//   When the receiver stalls, the output holds and a finished frame waits in
//   the snapshot register. With both of them held the accumulate stage
//   halts; the input register and then a one-entry skid buffer fill, and
//   in_stall rises only once the skid buffer holds the transfer in flight.
// ----------------------------------------------------------------------------
module pose_frame_decoder_core
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               chunk_end,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [29:0]        tag_id,
    output logic signed [24:0] x_pos,
    output logic signed [14:0] y_pos,
    output logic signed [14:0] yaw_deci_deg,
    output logic signed [21:0] yaw_rad_q16,
    output logic               range_error
);

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic        skid_full_reg;
    logic [7:0]  skid_byte_reg;
    logic        skid_end_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        snap_valid_reg;
    pfd_pkg::frame_snap_t snap_reg;
    logic        out_valid_reg;

    logic        in_take;
    logic        out_free;
    logic        snap_free;
    logic        snap_adv;
    logic        acc_go;
    logic        in_reg_free;

    assign in_stall    = skid_full_reg;
    assign in_take     = in_valid && !skid_full_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign snap_adv    = snap_valid_reg && out_free;
    assign snap_free   = !snap_valid_reg || out_free;
    assign acc_go      = in_valid_reg && snap_free;
    assign in_reg_free = !in_valid_reg || acc_go;

    // ------------------------------------------------------------------
    // Input register with skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            if (skid_full_reg)
            begin
                if (in_reg_free)
                begin
                    skid_full_reg <= 1'b0;
                    in_valid_reg  <= 1'b1;
                end
            end
            else if (in_reg_free)
            begin
                in_valid_reg <= in_take;
            end
            else if (in_take)
            begin
                skid_full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (in_reg_free)
            begin
                in_byte_reg <= skid_byte_reg;
                in_end_reg  <= skid_end_reg;
            end
        end
        else if (in_take)
        begin
            if (in_reg_free)
            begin
                in_byte_reg <= data_byte;
                in_end_reg  <= chunk_end;
            end
            else
            begin
                skid_byte_reg <= data_byte;
                skid_end_reg  <= chunk_end;
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame accumulation
    // ------------------------------------------------------------------
    logic [4:0]  byte_index_reg, byte_index_next;
    logic [7:0]  xor_sum_reg, xor_sum_next;
    logic        on_code_flag_reg, on_code_flag_next;
    logic [29:0] x_accum_reg, x_accum_next;
    logic [15:0] y_accum_reg, y_accum_next;
    logic [15:0] angle_accum_reg, angle_accum_next;
    logic [29:0] tag_accum_reg, tag_accum_next;
    logic        in_frame;
    logic        frame_good;
    logic [13:0] ang_clamped;
    logic signed [14:0] yaw_wrapped;

    assign in_frame = (byte_index_reg < pfd_pkg::FRAME_LEN);

    always_comb
    begin
        byte_index_next   = byte_index_reg;
        xor_sum_next      = xor_sum_reg;
        on_code_flag_next = on_code_flag_reg;
        x_accum_next      = x_accum_reg;
        y_accum_next      = y_accum_reg;
        angle_accum_next  = angle_accum_reg;
        tag_accum_next    = tag_accum_reg;
        if (in_frame)
        begin
            byte_index_next = byte_index_reg + 5'd1;
            xor_sum_next    = xor_sum_reg ^ in_byte_reg;
            if (byte_index_reg == pfd_pkg::IDX_FLAG)
            begin
                on_code_flag_next = in_byte_reg[pfd_pkg::FLAG_BIT];
            end
            if (byte_index_reg >= pfd_pkg::IDX_X_FIRST && byte_index_reg <= pfd_pkg::IDX_X_LAST)
            begin
                x_accum_next = {x_accum_reg[22:0], 7'd0} + {22'd0, in_byte_reg};
            end
            if (byte_index_reg == pfd_pkg::IDX_Y_FIRST || byte_index_reg == pfd_pkg::IDX_Y_LAST)
            begin
                y_accum_next = {y_accum_reg[8:0], 7'd0} + {8'd0, in_byte_reg};
            end
            if (byte_index_reg == pfd_pkg::IDX_ANG_FIRST
                || byte_index_reg == pfd_pkg::IDX_ANG_LAST)
            begin
                angle_accum_next = {angle_accum_reg[8:0], 7'd0} + {8'd0, in_byte_reg};
            end
            if (byte_index_reg >= pfd_pkg::IDX_TAG_FIRST
                && byte_index_reg <= pfd_pkg::IDX_TAG_LAST)
            begin
                tag_accum_next = {tag_accum_reg[22:0], 7'd0} + {22'd0, in_byte_reg};
            end
        end
    end

    assign frame_good = (byte_index_next == pfd_pkg::FRAME_LEN) && (xor_sum_next == 8'd0)
                        && on_code_flag_next;

    // clamp to 14 bits, then fold the upper half-turn to negative
    assign ang_clamped = (angle_accum_next[15:14] != 2'd0) ? pfd_pkg::ANG_MAX
                                                           : angle_accum_next[13:0];
    assign yaw_wrapped = (ang_clamped > pfd_pkg::ANG_HALF)
                         ? $signed({1'b0, ang_clamped} - pfd_pkg::ANG_FULL)
                         : $signed({1'b0, ang_clamped});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            xor_sum_reg      <= '0;
            on_code_flag_reg <= 1'b0;
            x_accum_reg      <= '0;
            y_accum_reg      <= '0;
            angle_accum_reg  <= '0;
            tag_accum_reg    <= '0;
        end
        else if (acc_go)
        begin
            if (in_end_reg)
            begin
                byte_index_reg   <= '0;
                xor_sum_reg      <= '0;
                on_code_flag_reg <= 1'b0;
                x_accum_reg      <= '0;
                y_accum_reg      <= '0;
                angle_accum_reg  <= '0;
                tag_accum_reg    <= '0;
            end
            else
            begin
                byte_index_reg   <= byte_index_next;
                xor_sum_reg      <= xor_sum_next;
                on_code_flag_reg <= on_code_flag_next;
                x_accum_reg      <= x_accum_next;
                y_accum_reg      <= y_accum_next;
                angle_accum_reg  <= angle_accum_next;
                tag_accum_reg    <= tag_accum_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Snapshot of a completed good frame
    // ------------------------------------------------------------------
    logic snap_load;

    assign snap_load = acc_go && in_end_reg && frame_good;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_free)
        begin
            snap_valid_reg <= snap_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_reg.x   <= x_accum_next;
            snap_reg.y   <= y_accum_next;
            snap_reg.yaw <= yaw_wrapped;
            snap_reg.tag <= tag_accum_next;
        end
    end

    // ------------------------------------------------------------------
    // Conversion into the output register
    // ------------------------------------------------------------------
    logic signed [24:0] x_conv;
    logic signed [14:0] y_conv;
    logic               x_err;
    logic               y_err;
    logic signed [31:0] yaw_prod;

    always_comb
    begin
        x_err = 1'b0;
        if (snap_reg.x <= pfd_pkg::X_HALF)
        begin
            x_conv = snap_reg.x[24:0];
        end
        else if (snap_reg.x <= pfd_pkg::X_SPAN)
        begin
            x_conv = snap_reg.x[24:0] - pfd_pkg::X_SPAN[24:0];
        end
        else
        begin
            x_conv = pfd_pkg::X_SAT;
            x_err  = 1'b1;
        end
    end

    always_comb
    begin
        y_err = 1'b0;
        if (snap_reg.y <= pfd_pkg::Y_HALF)
        begin
            y_conv = snap_reg.y[14:0];
        end
        else if (snap_reg.y <= pfd_pkg::Y_SPAN)
        begin
            y_conv = snap_reg.y[14:0] - pfd_pkg::Y_SPAN[14:0];
        end
        else
        begin
            y_conv = pfd_pkg::Y_SAT;
            y_err  = 1'b1;
        end
    end

    // arithmetic shift floors, as required for negative yaw
    assign yaw_prod = $signed({{17{snap_reg.yaw[14]}}, snap_reg.yaw}) * pfd_pkg::YAW_SCALE
                      + pfd_pkg::YAW_ROUND;

    logic [29:0]        tag_id_reg;
    logic signed [24:0] x_pos_reg;
    logic signed [14:0] y_pos_reg;
    logic signed [14:0] yaw_deci_deg_reg;
    logic signed [21:0] yaw_rad_q16_reg;
    logic               range_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            tag_id_reg       <= snap_reg.tag;
            x_pos_reg        <= x_conv;
            y_pos_reg        <= y_conv;
            yaw_deci_deg_reg <= snap_reg.yaw;
            yaw_rad_q16_reg  <= yaw_prod[29:8];
            range_error_reg  <= x_err || y_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tag_id       = tag_id_reg;
    assign x_pos        = x_pos_reg;
    assign y_pos        = y_pos_reg;
    assign yaw_deci_deg = yaw_deci_deg_reg;
    assign yaw_rad_q16  = yaw_rad_q16_reg;
    assign range_error  = range_error_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_input: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> in_valid_reg)
        else $error("skid entry occupied while input register empty");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= pfd_pkg::FRAME_LEN)
        else $error("byte index beyond frame length");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_go && in_end_reg) |=> (byte_index_reg == 5'd0 && xor_sum_reg == 8'd0))
        else $error("frame state not cleared after chunk end");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (yaw_deci_deg_reg >= -15'sd1799 && yaw_deci_deg_reg <= 15'sd12783))
        else $error("yaw outside folded range");

endmodule
